FILE: src/mprd_pkg.sv
package mprd_pkg;

   localparam int MAX_WIDTH = 128;
   localparam int MAX_PAGES = 8;
   localparam int DEPTH     = MAX_WIDTH * MAX_PAGES;
   localparam int AW        = $clog2(DEPTH);
   localparam int WW        = $clog2(MAX_WIDTH + 1);
   localparam int HW        = $clog2(MAX_PAGES * 8 + 1);
   localparam int PGW       = $clog2(MAX_PAGES + 1);
   localparam int NW        = $clog2(DEPTH + 1);

   localparam logic [2:0] OP_PIXEL = 3'd0;
   localparam logic [2:0] OP_HLINE = 3'd1;
   localparam logic [2:0] OP_VLINE = 3'd2;
   localparam logic [2:0] OP_RECT  = 3'd3;
   localparam logic [2:0] OP_FILL  = 3'd4;
   localparam logic [2:0] OP_READ  = 3'd5;

   localparam logic [1:0] COLOR_BLACK   = 2'd0;
   localparam logic [1:0] COLOR_WHITE   = 2'd1;
   localparam logic [1:0] COLOR_INVERSE = 2'd2;
   localparam logic [1:0] COLOR_INVALID = 2'd3;

   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   localparam logic [7:0] RST_WIDTH  = 8'd128;
   localparam logic [6:0] RST_HEIGHT = 7'd64;

   typedef enum logic [2:0] {
      PX_SET,
      PX_CLR,
      PX_TOG,
      PX_WRB,
      PX_RD
   } px_op_type;

   typedef struct packed {
      logic            valid;
      px_op_type       op;
      logic [AW-1:0]   addr;
      logic [7:0]      mask;
      logic [7:0]      wdata;
   } px_cmd_type;

   typedef struct packed {
      logic [WW-1:0]  width;
      logic [HW-1:0]  height;
      logic [PGW-1:0] pages;
      logic [NW-1:0]  bytes;
   } geom_type;

   typedef struct packed {
      logic done;
      logic error;
      logic rd_ok;
      logic clearing;
   } seq_stat_type;

endpackage

FILE: src/mprd_ram.sv
module mprd_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [AW-1:0]     raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/mprd_rmw.sv
module mprd_rmw (
   input  logic                   clock,
   input  logic                   reset,
   input  mprd_pkg::px_cmd_type   px_cmd,
   output logic [7:0]             rd_data
);
   import mprd_pkg::*;

   px_cmd_type    s2_ff, s2_in;
   logic          fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0] fwd_addr_ff, fwd_addr_in;
   logic [7:0]    fwd_data_ff, fwd_data_in;
   logic [7:0]    rd_data_ff, rd_data_in;
   logic [7:0]    ram_rdata;
   logic [7:0]    old_byte;
   logic [7:0]    new_byte;
   logic          wr_en;

   mprd_ram #(
      .DATA_W(8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (s2_ff.addr),
      .wdata (new_byte),
      .raddr (px_cmd.addr),
      .rdata (ram_rdata)
   );

   // the write of the previous cycle is not yet visible in the read data
   always_comb begin
      old_byte = (fwd_valid_ff && (fwd_addr_ff == s2_ff.addr)) ? fwd_data_ff : ram_rdata;
      case (s2_ff.op)
         PX_SET:  new_byte = old_byte | s2_ff.mask;
         PX_CLR:  new_byte = old_byte & ~s2_ff.mask;
         PX_TOG:  new_byte = old_byte ^ s2_ff.mask;
         PX_WRB:  new_byte = s2_ff.wdata;
         default: new_byte = old_byte;
      endcase
      wr_en        = s2_ff.valid && (s2_ff.op != PX_RD);
      s2_in        = px_cmd;
      fwd_valid_in = wr_en;
      fwd_addr_in  = s2_ff.addr;
      fwd_data_in  = new_byte;
      rd_data_in   = (s2_ff.valid && (s2_ff.op == PX_RD)) ? old_byte : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff        <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s2_ff        <= s2_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
      rd_data_ff  <= rd_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/mprd_seq.sv
module mprd_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_operation,
   input  logic [7:0]             req_start_x,
   input  logic [7:0]             req_start_y,
   input  logic [7:0]             req_end_x,
   input  logic [7:0]             req_end_y,
   input  logic [1:0]             req_line_color,
   input  logic [1:0]             req_fill_color,
   input  logic [2:0]             req_page,
   input  mprd_pkg::geom_type     geom,
   input  logic                   rsp_free,
   output mprd_pkg::px_cmd_type   px_cmd,
   output mprd_pkg::seq_stat_type stat
);
   import mprd_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_FILL  = 7'b0000100,
      ST_DRAW  = 7'b0001000,
      ST_READ  = 7'b0010000,
      ST_DRAIN = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      SEG_ONLY,
      SEG_TOP,
      SEG_BOT,
      SEG_LEFT,
      SEG_RIGHT,
      SEG_FILL
   } seg_type;

   state_type     state_ff, state_in;
   seg_type       seg_ff, seg_in;
   logic [7:0]    sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [1:0]    lc_ff, lc_in, fc_ff, fc_in, color_ff, color_in;
   logic [2:0]    pg_ff, pg_in;
   logic          err_ff, err_in, rd_ok_ff, rd_ok_in;
   logic          horiz_ff, horiz_in;
   logic [7:0]    fixed_ff, fixed_in;
   logic [8:0]    cur_ff, cur_in, end_ff, end_in, row_ff, row_in;
   logic [NW-1:0] cnt_ff, cnt_in;

   logic [7:0]    px_x, px_y;
   logic [PGW-1:0] px_page;
   logic          seg_live, oob, rd_ok;
   logic [7:0]    addr_x;
   logic [PGW-1:0] addr_pg;
   logic [AW-1:0] pix_addr;
   logic [8:0]    row_next;
   px_op_type     color_op;

   always_comb begin
      px_x     = horiz_ff ? cur_ff[7:0] : fixed_ff;
      px_y     = horiz_ff ? fixed_ff : cur_ff[7:0];
      px_page  = px_y[PGW+2:3];
      seg_live = (cur_ff < end_ff) && ((seg_ff != SEG_FILL) || (row_ff < {1'b0, ey_ff}));
      oob      = (px_x >= geom.width) || (px_y >= geom.height);
      rd_ok    = (sx_ff < geom.width) && (pg_ff < geom.pages);
      addr_x   = (state_ff == ST_READ) ? sx_ff : px_x;
      addr_pg  = (state_ff == ST_READ) ? PGW'(pg_ff) : px_page;
      pix_addr = AW'(addr_x) + AW'(AW'(addr_pg) * AW'(geom.width));
      row_next = row_ff + 9'd1;
      case (color_ff)
         COLOR_WHITE: color_op = PX_SET;
         COLOR_BLACK: color_op = PX_CLR;
         default:     color_op = PX_TOG;
      endcase
   end

   always_comb begin
      px_cmd       = '0;
      px_cmd.addr  = pix_addr;
      px_cmd.mask  = 8'b1 << px_y[2:0];
      case (state_ff)
         ST_CLEAR: begin
            px_cmd.valid = 1'b1;
            px_cmd.op    = PX_WRB;
            px_cmd.addr  = cnt_ff[AW-1:0];
            px_cmd.wdata = 8'h00;
         end
         ST_FILL: begin
            px_cmd.valid = cnt_ff < geom.bytes;
            px_cmd.op    = PX_WRB;
            px_cmd.addr  = cnt_ff[AW-1:0];
            px_cmd.wdata = (lc_ff == COLOR_BLACK) ? 8'h00 : 8'hff;
         end
         ST_DRAW: begin
            px_cmd.valid = seg_live && !oob && (color_ff != COLOR_INVALID);
            px_cmd.op    = color_op;
         end
         ST_READ: begin
            px_cmd.valid = rd_ok;
            px_cmd.op    = PX_RD;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      ex_in    = ex_ff;
      ey_in    = ey_ff;
      lc_in    = lc_ff;
      fc_in    = fc_ff;
      pg_in    = pg_ff;
      color_in = color_ff;
      err_in   = err_ff;
      rd_ok_in = rd_ok_ff;
      horiz_in = horiz_ff;
      fixed_in = fixed_ff;
      cur_in   = cur_ff;
      end_in   = end_ff;
      row_in   = row_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff[AW-1:0] == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               sx_in    = req_start_x;
               sy_in    = req_start_y;
               ex_in    = req_end_x;
               ey_in    = req_end_y;
               lc_in    = req_line_color;
               fc_in    = req_fill_color;
               pg_in    = req_page;
               color_in = req_line_color;
               err_in   = 1'b0;
               rd_ok_in = 1'b0;
               cnt_in   = '0;
               seg_in   = SEG_ONLY;
               state_in = ST_DRAW;
               case (req_operation)
                  OP_PIXEL: begin
                     horiz_in = 1'b0;
                     fixed_in = req_start_x;
                     cur_in   = {1'b0, req_start_y};
                     end_in   = {1'b0, req_start_y} + 9'd1;
                  end
                  OP_HLINE: begin
                     horiz_in = 1'b1;
                     fixed_in = req_start_y;
                     cur_in   = {1'b0, req_start_x};
                     end_in   = {1'b0, req_end_x};
                  end
                  OP_VLINE: begin
                     horiz_in = 1'b0;
                     fixed_in = req_start_x;
                     cur_in   = {1'b0, req_start_y};
                     end_in   = {1'b0, req_end_y};
                  end
                  OP_RECT: begin
                     seg_in   = SEG_TOP;
                     horiz_in = 1'b1;
                     fixed_in = req_start_y;
                     cur_in   = {1'b0, req_start_x};
                     end_in   = {1'b0, req_end_x};
                  end
                  OP_FILL: state_in = ST_FILL;
                  OP_READ: state_in = ST_READ;
                  default: begin
                     err_in   = 1'b1;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FILL: begin
            if (cnt_ff < geom.bytes) begin
               cnt_in = cnt_ff + NW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAW: begin
            if (seg_live) begin
               if (oob || (color_ff == COLOR_INVALID)) begin
                  err_in = 1'b1;
               end
               cur_in = cur_ff + 9'd1;
            end else begin
               case (seg_ff)
                  SEG_TOP: begin
                     seg_in   = SEG_BOT;
                     fixed_in = ey_ff;
                     cur_in   = {1'b0, sx_ff};
                  end
                  SEG_BOT: begin
                     seg_in   = SEG_LEFT;
                     horiz_in = 1'b0;
                     fixed_in = sx_ff;
                     cur_in   = {1'b0, sy_ff};
                     end_in   = {1'b0, ey_ff};
                  end
                  SEG_LEFT: begin
                     seg_in   = SEG_RIGHT;
                     fixed_in = ex_ff;
                     cur_in   = {1'b0, sy_ff};
                     end_in   = {1'b0, ey_ff + 8'd1};
                  end
                  SEG_RIGHT: begin
                     seg_in   = SEG_FILL;
                     horiz_in = 1'b1;
                     row_in   = {1'b0, sy_ff} + 9'd1;
                     fixed_in = sy_ff + 8'd1;
                     cur_in   = {1'b0, sx_ff + 8'd1};
                     end_in   = {1'b0, ex_ff};
                     color_in = fc_ff;
                  end
                  SEG_FILL: begin
                     if ((row_ff < {1'b0, ey_ff}) && (row_next < {1'b0, ey_ff})) begin
                        row_in   = row_next;
                        fixed_in = row_next[7:0];
                        cur_in   = {1'b0, sx_ff + 8'd1};
                     end else begin
                        state_in = ST_DRAIN;
                     end
                  end
                  default: state_in = ST_DRAIN;
               endcase
            end
         end
         ST_READ: begin
            err_in   = !rd_ok;
            rd_ok_in = rd_ok;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff   <= seg_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      lc_ff    <= lc_in;
      fc_ff    <= fc_in;
      pg_ff    <= pg_in;
      color_ff <= color_in;
      err_ff   <= err_in;
      rd_ok_ff <= rd_ok_in;
      horiz_ff <= horiz_in;
      fixed_ff <= fixed_in;
      cur_ff   <= cur_in;
      end_ff   <= end_in;
      row_ff   <= row_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign stat.done     = (state_ff == ST_DONE) && rsp_free;
   assign stat.error    = err_ff;
   assign stat.rd_ok    = rd_ok_ff;
   assign stat.clearing = (state_ff == ST_CLEAR);

endmodule

FILE: src/mono_page_raster_draw.sv
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------
// req      | req_valid / req_ready  | operation, start/end x/y, colors, page
// rsp      | rsp_valid / rsp_ready  | error, read_data
// csr      | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// One framebuffer read-modify-write per cycle sets the rate while a command
// is drawn: a command visits each pixel of each segment in turn (each fill row
// is one), then drains; fill screen writes width * pages bytes, read byte one.
// After reset the whole framebuffer is cleared while req_ready is low.
// A result waits in the output register; the next item is taken meanwhile.
// A finished command holds in its last cycle until that register is free.
module mono_page_raster_draw (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_start_x,
   input  logic [7:0]  req_start_y,
   input  logic [7:0]  req_end_x,
   input  logic [7:0]  req_end_y,
   input  logic [1:0]  req_line_color,
   input  logic [1:0]  req_fill_color,
   input  logic [2:0]  req_page,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_error,
   output logic [7:0]  rsp_read_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mprd_pkg::*;

   logic [7:0]   screen_width_ff, screen_width_in;
   logic [6:0]   screen_height_ff, screen_height_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_error_ff, rsp_error_in;
   logic [7:0]   rsp_data_ff, rsp_data_in;
   logic         csr_write;
   logic [HW:0]  pages_sum;
   logic         rsp_free;
   logic [7:0]   rd_data;
   geom_type     geom;
   px_cmd_type   px_cmd;
   seq_stat_type stat;

   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_HEIGHT) ? 32'(screen_height_ff) : 32'(screen_width_ff);

   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_WIDTH:  screen_width_in  = pwdata[7:0];
            REG_HEIGHT: screen_height_in = pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      geom.width  = (int'(screen_width_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(screen_width_ff);
      geom.height = (int'(screen_height_ff) > MAX_PAGES * 8) ? HW'(MAX_PAGES * 8)
                                                             : HW'(screen_height_ff);
      pages_sum   = {1'b0, geom.height} + (HW + 1)'(7);
      geom.pages  = PGW'(pages_sum >> 3);
      geom.bytes  = NW'(NW'(geom.width) * NW'(geom.pages));
   end

   mprd_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_line_color (req_line_color),
      .req_fill_color (req_fill_color),
      .req_page       (req_page),
      .geom           (geom),
      .rsp_free       (rsp_free),
      .px_cmd         (px_cmd),
      .stat           (stat)
   );

   mprd_rmw u_rmw (
      .clock   (clock),
      .reset   (reset),
      .px_cmd  (px_cmd),
      .rd_data (rd_data)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_error_in = rsp_error_ff;
      rsp_data_in  = rsp_data_ff;
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_error_in = stat.error;
         rsp_data_in  = stat.rd_ok ? rd_data : 8'h00;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= RST_WIDTH;
         screen_height_ff <= RST_HEIGHT;
         rsp_valid_ff     <= 1'b0;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_error_ff <= rsp_error_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_error     = rsp_error_ff;
   assign rsp_read_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(stat.done))
      else $error("result raised without a finished command");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !req_ready)
      else $error("item accepted during framebuffer clear");

   a_no_pixel_on_accept: assert property (@(posedge clock) disable iff (reset)
      px_cmd.valid |-> !req_ready)
      else $error("framebuffer access while idle");

   a_err_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_read_data == 8'h00))
      else $error("read data on failed command");
`endif

endmodule

FILE: sim/mono_page_raster_draw_tb.sv
`timescale 1ns / 1ps

module mono_page_raster_draw_tb;
   import mprd_pkg::*;

   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;
   localparam int N_GEOM = 9;
   localparam int CMDS_PER_GEOM = 130;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] sx;
      logic [7:0] sy;
      logic [7:0] ex;
      logic [7:0] ey;
      logic [1:0] lc;
      logic [1:0] fc;
      logic [2:0] pg;
   } draw_cmd_t;

   typedef struct packed {
      logic       error;
      logic [7:0] data;
   } draw_status_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = '0;
   logic [7:0]  req_start_x = '0;
   logic [7:0]  req_start_y = '0;
   logic [7:0]  req_end_x = '0;
   logic [7:0]  req_end_y = '0;
   logic [1:0]  req_line_color = '0;
   logic [1:0]  req_fill_color = '0;
   logic [2:0]  req_page = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_error;
   logic [7:0]  rsp_read_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   mono_page_raster_draw i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_line_color (req_line_color),
      .req_fill_color (req_fill_color),
      .req_page       (req_page),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_error      (rsp_error),
      .rsp_read_data  (rsp_read_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // shadow framebuffer and geometry
   logic [7:0]   shadow_fb [DEPTH];
   int           shadow_width = 128;
   int           shadow_height = 64;

   draw_cmd_t    draw_queue [$];
   draw_status_t status_queue [$];
   draw_cmd_t    offered;
   int           cmd_total = 0;
   int           resp_seen = 0;
   int           fault_count = 0;
   int           op_count [8] = '{default: 0};
   int           send_idle = 0;
   int           recv_idle = 0;
   logic         rsp_hold = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #48_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int span_w();
      return (shadow_width > MAX_WIDTH) ? MAX_WIDTH : shadow_width;
   endfunction

   function automatic int span_h();
      return (shadow_height > MAX_PAGES * 8) ? MAX_PAGES * 8 : shadow_height;
   endfunction

   function automatic logic fb_plot(int x, int y, logic [1:0] color);
      int w;
      int idx;
      logic [7:0] mask;
      w = span_w();
      if (x >= w || y >= span_h()) return 1'b1;
      idx = x + (y / 8) * w;
      mask = 8'd1 << (y % 8);
      case (color)
         COLOR_WHITE:   shadow_fb[idx] = shadow_fb[idx] | mask;
         COLOR_BLACK:   shadow_fb[idx] = shadow_fb[idx] & ~mask;
         COLOR_INVERSE: shadow_fb[idx] = shadow_fb[idx] ^ mask;
         default:       return 1'b1;
      endcase
      return 1'b0;
   endfunction

   function automatic logic fb_hline(int sx, int y, int ex, logic [1:0] color);
      logic err;
      err = 1'b0;
      for (int i = sx; i < ex; i++) err |= fb_plot(i, y, color);
      return err;
   endfunction

   function automatic logic fb_vline(int x, int sy, int ey, logic [1:0] color);
      logic err;
      err = 1'b0;
      for (int i = sy; i < ey; i++) err |= fb_plot(x, i, color);
      return err;
   endfunction

   function automatic draw_status_t apply_draw(draw_cmd_t c);
      draw_status_t s;
      int w;
      int pages;
      s = '0;
      w = span_w();
      pages = (span_h() + 7) / 8;
      case (c.op)
         OP_PIXEL: s.error = fb_plot(c.sx, c.sy, c.lc);
         OP_HLINE: s.error = fb_hline(c.sx, c.sy, c.ex, c.lc);
         OP_VLINE: s.error = fb_vline(c.sx, c.sy, c.ey, c.lc);
         OP_RECT: begin
            s.error = fb_hline(c.sx, c.sy, c.ex, c.lc);
            s.error |= fb_hline(c.sx, c.ey, c.ex, c.lc);
            s.error |= fb_vline(c.sx, c.sy, c.ey, c.lc);
            s.error |= fb_vline(c.ex, c.sy, (int'(c.ey) + 1) % 256, c.lc);
            for (int r = int'(c.sy) + 1; r < int'(c.ey); r++)
               s.error |= fb_hline((int'(c.sx) + 1) % 256, r, c.ex, c.fc);
         end
         OP_FILL: begin
            for (int i = 0; i < w * pages; i++)
               shadow_fb[i] = (c.lc == COLOR_BLACK) ? 8'h00 : 8'hFF;
         end
         OP_READ: begin
            if (int'(c.sx) < w && int'(c.pg) < pages)
               s.data = shadow_fb[int'(c.sx) + int'(c.pg) * w];
            else
               s.error = 1'b1;
         end
         default: s.error = 1'b1;
      endcase
      return s;
   endfunction

   function automatic void queue_cmd(draw_cmd_t c);
      draw_queue.push_back(c);
      cmd_total++;
   endfunction

   function automatic void draw(logic [2:0] op, logic [7:0] sx, logic [7:0] sy,
                                logic [7:0] ex, logic [7:0] ey, logic [1:0] lc,
                                logic [1:0] fc, logic [2:0] pg);
      queue_cmd('{op, sx, sy, ex, ey, lc, fc, pg});
   endfunction

   function automatic logic [7:0] pick_coord(int lim, bit wide);
      int v;
      v = wide ? $urandom_range(255) : $urandom_range(lim + 1);
      return (v > 255) ? 8'd255 : 8'(v);
   endfunction

   function automatic draw_cmd_t random_cmd();
      draw_cmd_t c;
      int w;
      int pg_n;
      int sel;
      int len;
      bit wide;
      bit big;
      w = span_w();
      pg_n = (span_h() + 7) / 8;
      wide = ($urandom_range(99) < 15);
      big = ($urandom_range(99) < 3);
      sel = $urandom_range(99);
      if (sel < 20) c.op = OP_PIXEL;
      else if (sel < 40) c.op = OP_HLINE;
      else if (sel < 60) c.op = OP_VLINE;
      else if (sel < 78) c.op = OP_RECT;
      else if (sel < 82) c.op = OP_FILL;
      else if (sel < 96) c.op = OP_READ;
      else c.op = $urandom_range(1) ? OP_RSVD6 : OP_RSVD7;
      c.sx = pick_coord(w, wide);
      c.sy = pick_coord(span_h(), wide);
      c.ex = $urandom_range(255);
      c.ey = $urandom_range(255);
      c.lc = ($urandom_range(99) < 8) ? COLOR_INVALID : 2'($urandom_range(2));
      c.fc = ($urandom_range(99) < 8) ? COLOR_INVALID : 2'($urandom_range(2));
      c.pg = $urandom_range(7);
      case (c.op)
         OP_HLINE: begin
            len = $urandom_range(44);
            if (!wide) c.ex = 8'(c.sx + len - 4);
         end
         OP_VLINE: begin
            len = $urandom_range(44);
            if (!wide) c.ey = 8'(c.sy + len - 4);
         end
         OP_RECT: begin
            len = $urandom_range(big ? 130 : 12);
            c.ex = 8'(c.sx + len - 1);
            len = $urandom_range(big ? 70 : 12);
            c.ey = 8'(c.sy + len - 1);
         end
         OP_READ: begin
            if (!wide) begin
               c.sx = (w == 0) ? 8'd0 : 8'($urandom_range(w - 1));
               c.pg = (pg_n == 0) ? 3'd0 : 3'($urandom_range(pg_n - 1));
            end
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic csr_write(input logic [0:0] idx, input int val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_WIDTH)
         shadow_width = val & 8'hFF;
      else
         shadow_height = val & 7'h7F;
   endtask

   task automatic wait_drained();
      while (resp_seen < cmd_total) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            status_queue.push_back(apply_draw(offered));
            op_count[offered.op]++;
         end
         if (!req_valid || req_ready) begin
            if (draw_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
               offered = draw_queue.pop_front();
               req_valid <= 1'b1;
               req_operation <= offered.op;
               req_start_x <= offered.sx;
               req_start_y <= offered.sy;
               req_end_x <= offered.ex;
               req_end_y <= offered.ey;
               req_line_color <= offered.lc;
               req_fill_color <= offered.fc;
               req_page <= offered.pg;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      draw_status_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            resp_seen++;
            if (status_queue.size() == 0) begin
               if (fault_count < 10)
                  $display("unexpected status: error=%0b data=%02h", rsp_error, rsp_read_data);
               fault_count++;
            end else begin
               want = status_queue.pop_front();
               if (rsp_error !== want.error || rsp_read_data !== want.data) begin
                  if (fault_count < 10)
                     $display("status %0d: expected error=%0b data=%02h, got error=%0b data=%02h",
                              resp_seen, want.error, want.data, rsp_error, rsp_read_data);
                  fault_count++;
               end
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      int geo_w [N_GEOM];
      int geo_h [N_GEOM];
      geo_w = '{255, 1, 37, 0, 128, 0, 100, 8, 128};
      geo_h = '{127, 1, 20, 0, 0, 64, 45, 8, 64};
      foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle <= 16;
      recv_idle <= 47;

      draw(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, COLOR_WHITE, COLOR_BLACK, 3'd0);
      draw(OP_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, COLOR_WHITE, COLOR_BLACK, 3'd7);
      draw(OP_PIXEL, 8'd128, 8'd0, 8'd0, 8'd0, COLOR_WHITE, COLOR_BLACK, 3'd0);
      draw(OP_PIXEL, 8'd0, 8'd64, 8'd0, 8'd0, COLOR_WHITE, COLOR_BLACK, 3'd0);
      draw(OP_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, COLOR_INVERSE, COLOR_INVALID, 3'd7);
      draw(OP_PIXEL, 8'd5, 8'd5, 8'd0, 8'd0, COLOR_INVALID, COLOR_WHITE, 3'd0);
      draw(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, COLOR_BLACK, COLOR_BLACK, 3'd0);
      draw(OP_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, COLOR_INVERSE, COLOR_BLACK, 3'd0);
      draw(OP_HLINE, 8'd0, 8'd8, 8'd128, 8'd0, COLOR_WHITE, COLOR_BLACK, 3'd0);
      draw(OP_HLINE, 8'd120, 8'd9, 8'd140, 8'd0, COLOR_WHITE, COLOR_BLACK, 3'd0);
      draw(OP_HLINE, 8'd20, 8'd3, 8'd5, 8'd0, COLOR_WHITE, COLOR_BLACK, 3'd0);
      draw(OP_VLINE, 8'd3, 8'd0, 8'd0, 8'd64, COLOR_INVERSE, COLOR_BLACK, 3'd0);
      draw(OP_VLINE, 8'd4, 8'd60, 8'd0, 8'd70, COLOR_WHITE, COLOR_BLACK, 3'd0);
      draw(OP_VLINE, 8'd6, 8'd9, 8'd0, 8'd9, COLOR_WHITE, COLOR_BLACK, 3'd0);
      draw(OP_RECT, 8'd10, 8'd10, 8'd20, 8'd18, COLOR_WHITE, COLOR_INVERSE, 3'd0);
      // the top-left corner flips twice with inverse
      draw(OP_RECT, 8'd30, 8'd20, 8'd40, 8'd30, COLOR_INVERSE, COLOR_INVERSE, 3'd0);
      // interior start wraps to column 0
      draw(OP_RECT, 8'd255, 8'd2, 8'd5, 8'd6, COLOR_WHITE, COLOR_WHITE, 3'd0);
      // right edge end wraps to 0
      draw(OP_RECT, 8'd50, 8'd250, 8'd54, 8'd255, COLOR_WHITE, COLOR_BLACK, 3'd0);
      draw(OP_RECT, 8'd60, 8'd30, 8'd64, 8'd34, COLOR_INVALID, COLOR_WHITE, 3'd0);
      draw(OP_READ, 8'd10, 8'd0, 8'd0, 8'd0, COLOR_BLACK, COLOR_BLACK, 3'd1);
      draw(OP_READ, 8'd3, 8'd0, 8'd0, 8'd0, COLOR_BLACK, COLOR_BLACK, 3'd7);
      draw(OP_FILL, 8'd0, 8'd0, 8'd0, 8'd0, COLOR_INVERSE, COLOR_BLACK, 3'd0);
      draw(OP_READ, 8'd127, 8'd0, 8'd0, 8'd0, COLOR_BLACK, COLOR_BLACK, 3'd7);
      draw(OP_READ, 8'd128, 8'd0, 8'd0, 8'd0, COLOR_BLACK, COLOR_BLACK, 3'd0);
      draw(OP_FILL, 8'd0, 8'd0, 8'd0, 8'd0, COLOR_BLACK, COLOR_WHITE, 3'd0);
      draw(OP_RSVD6, 8'd1, 8'd1, 8'd2, 8'd2, COLOR_WHITE, COLOR_WHITE, 3'd0);
      draw(OP_RSVD7, 8'd1, 8'd1, 8'd2, 8'd2, COLOR_WHITE, COLOR_WHITE, 3'd0);

      for (int k = 0; k < N_GEOM; k++) begin
         wait_drained();
         csr_write(REG_WIDTH, geo_w[k]);
         csr_write(REG_HEIGHT, geo_h[k]);
         if (k == 3) begin
            send_idle <= 47;
            recv_idle <= 16;
         end else if (k == 6) begin
            send_idle <= 0;
            recv_idle <= 0;
         end
         for (int n = 0; n < CMDS_PER_GEOM; n++) queue_cmd(random_cmd());
         if (k == N_GEOM - 1) begin
            // long backpressure while items keep coming
            @(posedge clock);
            rsp_hold <= 1'b1;
            repeat (3000) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (status_queue.size() != 0) begin
         $display("%0d statuses never arrived", status_queue.size());
         fault_count++;
      end
      $display("ran %0d commands over %0d geometries: pixel %0d, hline %0d, vline %0d, rect %0d",
               cmd_total, N_GEOM + 1, op_count[OP_PIXEL], op_count[OP_HLINE],
               op_count[OP_VLINE], op_count[OP_RECT]);
      $display("fill %0d, read %0d, reserved %0d; %0d statuses seen, %0d faults",
               op_count[OP_FILL], op_count[OP_READ], op_count[OP_RSVD6] + op_count[OP_RSVD7],
               resp_seen, fault_count);
      if (fault_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
src/mprd_pkg.sv
src/mprd_ram.sv
src/mprd_rmw.sv
src/mprd_seq.sv
src/mono_page_raster_draw.sv
sim/mono_page_raster_draw_tb.sv
